@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the console writer checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TCW_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcw check failed");

// next-cycle implication
`define TCW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcw check failed");

`endif

@@ design/tcw_pkg.sv @@
// ---------------------------------------------------------------------------
// tcw_pkg
// Types, codes and default geometry of the text console writer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;
  localparam int CELL_W   = 16;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] ATTR_RESET = 8'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL
  } tcw_state_t;

endpackage

@@ design/text_console_writer.sv @@
// ---------------------------------------------------------------------------
// text_console_writer
// Character-cell text screen writer with cursor, scroll, clear and cell read.
// ---------------------------------------------------------------------------
//  channel  | ports                                       | handshake
//  ---------+---------------------------------------------+---------------------
//  input    | in_kind, in_char_code, in_cell_index        | start & !busy
//  result   | out_cell_value, out_cursor_col/row, scrolled| out_valid, 1 cycle
//  config   | cfg_wr_data                                 | cfg_wr_en
//
//  Put without scroll: result strobed the next cycle.
//  Read: the cell comes from the RAM's registered read in ST_READ, then is registered out.
//  Scroll: a row copy in ST_COPY, then a blank fill of the last row in ST_FILL,
//  one cell per cycle through the screen RAM's single write port.
//  Clear: a blank fill of every cell. After reset busy stays high for a
//  zeroing pass over every cell. The result side cannot stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,
  output logic        out_valid,
  output logic [15:0] out_cell_value,
  output logic [6:0]  out_cursor_col,
  output logic [4:0]  out_cursor_row,
  output logic        out_scrolled,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int IW    = (AW > 11) ? AW : 11;

  tcw_state_t state_r, state_nxt;

  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic [CELL_W-1:0] fill_val_r, fill_val_nxt;
  logic              report_r, report_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [7:0]        attr_r;
  logic              scr_r, scr_nxt;
  logic              rd_ok_r, rd_ok_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_cell_r, out_cell_nxt;
  logic [6:0]        out_col_r, out_col_nxt;
  logic [4:0]        out_row_r, out_row_nxt;
  logic              out_scr_r, out_scr_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  logic              accept;
  logic [IW-1:0]     idx_w;
  logic              idx_ok;
  logic [CW:0]       col_inc;
  logic [RW:0]       row_inc;
  logic [AW-1:0]     pos;
  logic [CELL_W-1:0] blank;
  logic              is_nl, is_cr, is_char;
  logic              put_wrap, put_scroll;

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign accept  = start && (state_r == ST_IDLE);
  assign idx_w   = IW'(in_cell_index);
  assign idx_ok  = ({21'd0, in_cell_index} < 32'(CELLS));
  assign col_inc = {1'b0, col_r} + (CW+1)'(1);
  assign row_inc = {1'b0, row_r} + (RW+1)'(1);
  assign pos     = AW'(row_r) * AW'(COLS) + AW'(col_r);
  assign blank   = {attr_r, CH_SPACE};
  assign is_nl   = (in_char_code == CH_NEWLINE);
  assign is_cr   = (in_char_code == CH_RETURN);
  assign is_char = !is_nl && !is_cr;
  // newline always moves down; a plain char only when the line is full
  assign put_wrap   = is_nl || (is_char && (col_inc == (CW+1)'(COLS)));
  assign put_scroll = put_wrap && (row_inc == (RW+1)'(ROWS));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_PUT:   state_nxt = put_scroll ? ST_COPY : ST_IDLE;
            KIND_CLEAR: state_nxt = ST_FILL;
            KIND_READ:  state_nxt = ST_READ;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      ST_COPY: begin
        if (cnt_r == CNTW'(CELLS)) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (cnt_r == CNTW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt      = cnt_r;
    fill_val_nxt = fill_val_r;
    report_nxt   = report_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    scr_nxt      = scr_r;
    rd_ok_nxt    = rd_ok_r;
    out_valid_nxt = 1'b0;
    out_cell_nxt  = out_cell_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_scr_nxt   = out_scr_r;
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = {attr_r, in_char_code};
    mem_raddr = cnt_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        mem_raddr = idx_w[AW-1:0];
        if (accept) begin
          rd_ok_nxt = idx_ok;
          case (in_kind)
            KIND_PUT: begin
              mem_we = is_char;
              if (put_wrap || is_cr) begin
                col_nxt = '0;
              end else begin
                col_nxt = col_inc[CW-1:0];
              end
              if (put_scroll) begin
                row_nxt = RW'(ROWS - 1);
                cnt_nxt = CNTW'(COLS);
              end else if (put_wrap) begin
                row_nxt = row_inc[RW-1:0];
              end
              scr_nxt = put_scroll;
              if (!put_scroll) begin
                out_valid_nxt = 1'b1;
                out_cell_nxt  = '0;
                out_col_nxt   = 7'(col_nxt);
                out_row_nxt   = 5'(row_nxt);
                out_scr_nxt   = 1'b0;
              end
            end
            KIND_CLEAR: begin
              col_nxt      = '0;
              row_nxt      = '0;
              scr_nxt      = 1'b0;
              cnt_nxt      = '0;
              fill_val_nxt = blank;
              report_nxt   = 1'b1;
            end
            KIND_READ: ;
            default: begin
              out_valid_nxt = 1'b1;
              out_cell_nxt  = '0;
              out_col_nxt   = 7'(col_r);
              out_row_nxt   = 5'(row_r);
              out_scr_nxt   = 1'b0;
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_cell_nxt  = rd_ok_r ? mem_rdata : '0;
        out_col_nxt   = 7'(col_r);
        out_row_nxt   = 5'(row_r);
        out_scr_nxt   = 1'b0;
      end
      ST_COPY: begin
        // read at cnt, write the previous beat's data one row up
        mem_we    = (cnt_r != CNTW'(COLS));
        mem_waddr = AW'(cnt_r - CNTW'(COLS + 1));
        mem_wdata = mem_rdata;
        if (cnt_r == CNTW'(CELLS)) begin
          cnt_nxt      = CNTW'(CELLS - COLS);
          fill_val_nxt = blank;
          report_nxt   = 1'b1;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        mem_wdata = fill_val_r;
        cnt_nxt   = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(CELLS - 1)) begin
          out_valid_nxt = report_r;
          out_cell_nxt  = '0;
          out_col_nxt   = 7'(col_r);
          out_row_nxt   = 5'(row_r);
          out_scr_nxt   = scr_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;   // zeroing pass
      cnt_r       <= '0;
      fill_val_r  <= '0;
      report_r    <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= ATTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_val_r  <= fill_val_nxt;
      report_r    <= report_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    scr_r      <= scr_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_cell_r <= out_cell_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_scr_r  <= out_scr_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_cell_value = out_cell_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_scrolled   = out_scr_r;

endmodule

@@ design/tcw_ram.sv @@
// ---------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/tcw_checker.sv @@
// ---------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcw_checker
  import tcw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_kind,
  input logic [10:0] in_cell_index,
  input logic        out_valid,
  input logic [15:0] out_cell_value,
  input logic [6:0]  out_cursor_col,
  input logic [4:0]  out_cursor_row,
  input logic        out_scrolled
);

  localparam int CELLS = COLS * ROWS;

  // out-of-range read returns a zero cell in its result
  `TCW_ASSERT(a_read_oob, clk, rst_n, start && !busy && in_kind == KIND_READ && {21'd0, in_cell_index} >= 32'(CELLS), ##2 (out_valid && out_cell_value == 16'd0))

  // visible cursor never leaves the screen
  `TCW_ASSERT(a_cursor_range, clk, rst_n, out_valid, {25'd0, out_cursor_col} < 32'(COLS) && {27'd0, out_cursor_row} < 32'(ROWS))

  // a scroll leaves the cursor at the start of the last row
  `TCW_ASSERT(a_scroll_home, clk, rst_n, out_valid && out_scrolled, out_cursor_col == 7'd0 && out_cursor_row == 5'(ROWS - 1))

  // clear always runs a fill pass
  `TCW_ASSERT_NXT(a_clear_busy, clk, rst_n, start && !busy && in_kind == KIND_CLEAR, busy && !out_valid)

endmodule

bind text_console_writer tcw_checker #(
  .COLS(COLS),
  .ROWS(ROWS)
) u_tcw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_kind       (in_kind),
  .in_cell_index (in_cell_index),
  .out_valid     (out_valid),
  .out_cell_value(out_cell_value),
  .out_cursor_col(out_cursor_col),
  .out_cursor_row(out_cursor_row),
  .out_scrolled  (out_scrolled)
);
